/* rtl/core/sed_pkg.sv */
// Shared types, widths and register codes for the speech endpoint detector.
package sed_pkg;

  localparam int unsigned MaxWindow       = 32;
  localparam int unsigned MaxFrameSamples = 1024;

  // Field widths fixed by the register map and the item formats
  localparam int unsigned WinW     = 6;
  localparam int unsigned ThrW     = 5;
  localparam int unsigned SampW    = 11;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // Widths that follow from the limits
  localparam int unsigned PtrW    = $clog2(MaxWindow);
  localparam int unsigned CntW    = $clog2(MaxWindow + 1);
  localparam int unsigned FsW     = $clog2(MaxFrameSamples + 1);
  localparam int unsigned WinExtW = (CntW > WinW) ? CntW : WinW;
  localparam int unsigned CmpW    = (CntW > ThrW) ? CntW : ThrW;
  localparam int unsigned FsExtW  = (FsW > SampW) ? FsW : SampW;

  localparam logic [WinW-1:0]  WindowRst       = WinW'(10);
  localparam logic [ThrW-1:0]  StartThrRst     = ThrW'(9);
  localparam logic [ThrW-1:0]  EndThrRst       = ThrW'(1);
  localparam logic [SampW-1:0] FrameSamplesRst = SampW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW        = 2'd0,
    CFG_START_THR     = 2'd1,
    CFG_END_THR       = 2'd2,
    CFG_FRAME_SAMPLES = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_EOS   = 1'b1
  } op_e;

  // Effective configuration, as seen by the sequencer
  typedef struct packed {
    logic [CntW-1:0] window;
    logic [ThrW-1:0] start_thr;
    logic [ThrW-1:0] end_thr;
    logic [FsW-1:0]  frame_samples;
    logic            clear_queue;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic             frame_is_speech;
    logic [SampW-1:0] tail_samples;
  } in_t;

  typedef struct packed {
    logic              frame_valid;
    logic [FrameW-1:0] frame_index;
    logic [SampW-1:0]  tail_out;
    logic              speech_active;
    logic [FrameW-1:0] segment_start;
    logic [FrameW-1:0] segment_end;
    logic [SampW-1:0]  segment_end_extra;
    logic              error;
    logic              last;
  } res_t;

  typedef struct packed {
    logic            we;
    logic [PtrW-1:0] waddr;
    logic            wdata;
    logic [PtrW-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/core/sed_intf.sv */
// Valid/ready channel interfaces for frames, results and register writes.
interface sed_frame_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic                       frame_is_speech;
  logic [sed_pkg::SampW-1:0]  tail_samples;

  modport source (output valid, output op, output frame_is_speech, output tail_samples,
                  input ready);
  modport sink   (input valid, input op, input frame_is_speech, input tail_samples,
                  output ready);
endinterface

interface sed_result_if;
  logic                       valid;
  logic                       ready;
  logic                       frame_valid;
  logic [sed_pkg::FrameW-1:0] frame_index;
  logic [sed_pkg::SampW-1:0]  tail_out;
  logic                       speech_active;
  logic [sed_pkg::FrameW-1:0] segment_start;
  logic [sed_pkg::FrameW-1:0] segment_end;
  logic [sed_pkg::SampW-1:0]  segment_end_extra;
  logic                       error;
  logic                       last;

  modport source (output valid, output frame_valid, output frame_index, output tail_out,
                  output speech_active, output segment_start, output segment_end,
                  output segment_end_extra, output error, output last, input ready);
  modport sink   (input valid, input frame_valid, input frame_index, input tail_out,
                  input speech_active, input segment_start, input segment_end,
                  input segment_end_extra, input error, input last, output ready);
endinterface

interface sed_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sed_pkg::CfgIdxW-1:0]  index;
  logic [sed_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/sed_cfg.sv */
// Configuration registers with clamping to the effective ranges.
module sed_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  sed_cfg_if.sink         cfg_i,
  output sed_pkg::cfg_t   cfg_o
);

  logic [sed_pkg::WinW-1:0]  window_q;
  logic [sed_pkg::ThrW-1:0]  start_thr_q;
  logic [sed_pkg::ThrW-1:0]  end_thr_q;
  logic [sed_pkg::SampW-1:0] frame_samples_q;
  logic                      wr_en;
  logic [sed_pkg::WinExtW-1:0] win_ext;
  logic [sed_pkg::FsExtW-1:0]  fs_ext;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q        <= sed_pkg::WindowRst;
      start_thr_q     <= sed_pkg::StartThrRst;
      end_thr_q       <= sed_pkg::EndThrRst;
      frame_samples_q <= sed_pkg::FrameSamplesRst;
    end else if (wr_en) begin
      unique case (sed_pkg::cfg_reg_e'(cfg_i.index))
        sed_pkg::CFG_WINDOW:        window_q        <= cfg_i.data[sed_pkg::WinW-1:0];
        sed_pkg::CFG_START_THR:     start_thr_q     <= cfg_i.data[sed_pkg::ThrW-1:0];
        sed_pkg::CFG_END_THR:       end_thr_q       <= cfg_i.data[sed_pkg::ThrW-1:0];
        sed_pkg::CFG_FRAME_SAMPLES: frame_samples_q <= cfg_i.data[sed_pkg::SampW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp window to 2..MaxWindow and frame size to MaxFrameSamples
  assign win_ext = sed_pkg::WinExtW'(window_q);
  assign fs_ext  = sed_pkg::FsExtW'(frame_samples_q);

  always_comb begin
    if (win_ext < sed_pkg::WinExtW'(2)) begin
      cfg_o.window = sed_pkg::CntW'(2);
    end else if (win_ext > sed_pkg::WinExtW'(sed_pkg::MaxWindow)) begin
      cfg_o.window = sed_pkg::CntW'(sed_pkg::MaxWindow);
    end else begin
      cfg_o.window = sed_pkg::CntW'(win_ext);
    end
    if (fs_ext > sed_pkg::FsExtW'(sed_pkg::MaxFrameSamples)) begin
      cfg_o.frame_samples = sed_pkg::FsW'(sed_pkg::MaxFrameSamples);
    end else begin
      cfg_o.frame_samples = sed_pkg::FsW'(fs_ext);
    end
    cfg_o.start_thr   = start_thr_q;
    cfg_o.end_thr     = end_thr_q;
    cfg_o.clear_queue = wr_en && (sed_pkg::cfg_reg_e'(cfg_i.index) == sed_pkg::CFG_WINDOW);
  end

endmodule

/* rtl/core/sed_flag_mem.sv */
// Flag ring storage: one write and one registered read per cycle.
module sed_flag_mem (
  input  logic              clk_i,
  input  sed_pkg::mem_req_t req_i,
  output logic              rdata_o
);

  logic mem_q [sed_pkg::MaxWindow];
  logic rdata_q;

  // Read returns the old contents on a same-entry write
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sed_seq.sv */
// Sequencer: queue pointers, speech count, segment marks and result forming.
module sed_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sed_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sed_pkg::in_t      in_i,
  input  logic              out_free_i,
  output logic              push_o,
  output sed_pkg::res_t     res_o,
  output sed_pkg::mem_req_t mem_o,
  input  logic              mem_rdata_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EVICT = 7'b0000010,
    ST_POP   = 7'b0000100,
    ST_DCHK  = 7'b0001000,
    ST_DPOP  = 7'b0010000,
    ST_DFIN  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [sed_pkg::PtrW-1:0]   head_q, head_d;
  logic [sed_pkg::CntW-1:0]   occ_q, occ_d;
  logic [sed_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       speech_q, speech_d;
  logic [sed_pkg::FrameW-1:0] qsf_q, qsf_d;
  logic [sed_pkg::FrameW-1:0] seen_q, seen_d;
  logic [sed_pkg::FrameW-1:0] start_q, start_d;
  logic [sed_pkg::FrameW-1:0] end_q, end_d;
  logic [sed_pkg::SampW-1:0]  extra_q, extra_d;
  logic                       ending_q, ending_d;
  logic                       fwd_q, fwd_d;
  logic                       all_sp_q, all_sp_d;

  // Item payload and pending result fields
  logic                       flag_q, flag_d;
  logic [sed_pkg::SampW-1:0]  tail_q, tail_d;
  logic                       r_valid_q, r_valid_d;
  logic [sed_pkg::FrameW-1:0] r_idx_q, r_idx_d;
  logic [sed_pkg::SampW-1:0]  r_tail_q, r_tail_d;
  logic                       r_err_q, r_err_d;
  logic                       r_last_q, r_last_d;

  logic                       accept;
  logic                       full;
  logic [sed_pkg::CntW:0]     slot_sum;
  logic [sed_pkg::CntW:0]     win_x;
  logic [sed_pkg::PtrW-1:0]   slot;
  logic [sed_pkg::CntW-1:0]   head_nx;
  logic [sed_pkg::PtrW-1:0]   head_inc;
  logic [sed_pkg::PtrW-1:0]   head_push;
  logic [sed_pkg::CntW-1:0]   cnt_push;
  logic [sed_pkg::FrameW-1:0] qsf_push;
  logic                       pop_flag;
  logic                       tail_bad;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Ring arithmetic: head stays below the window, head + occupancy below twice it
  assign full     = (occ_q == cfg_i.window);
  assign slot_sum = (sed_pkg::CntW+1)'(head_q) + (sed_pkg::CntW+1)'(occ_q);
  assign win_x    = (sed_pkg::CntW+1)'(cfg_i.window);
  assign slot     = (slot_sum >= win_x) ? sed_pkg::PtrW'(slot_sum - win_x)
                                        : sed_pkg::PtrW'(slot_sum);
  assign head_nx  = sed_pkg::CntW'(head_q) + sed_pkg::CntW'(1);
  assign head_inc = (head_nx == cfg_i.window) ? '0 : sed_pkg::PtrW'(head_nx);

  assign head_push = full ? head_inc : head_q;
  assign cnt_push  = cnt_q - sed_pkg::CntW'(full & mem_rdata_i) + sed_pkg::CntW'(flag_q);
  assign qsf_push  = qsf_q + sed_pkg::FrameW'(full);
  assign pop_flag  = fwd_q ? flag_q : mem_rdata_i;
  assign tail_bad  = sed_pkg::FsExtW'(in_i.tail_samples) >
                     sed_pkg::FsExtW'(cfg_i.frame_samples);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    head_d    = head_q;
    occ_d     = occ_q;
    cnt_d     = cnt_q;
    speech_d  = speech_q;
    qsf_d     = qsf_q;
    seen_d    = seen_q;
    start_d   = start_q;
    end_d     = end_q;
    extra_d   = extra_q;
    ending_d  = ending_q;
    fwd_d     = fwd_q;
    all_sp_d  = all_sp_q;
    flag_d    = flag_q;
    tail_d    = tail_q;
    r_valid_d = r_valid_q;
    r_idx_d   = r_idx_q;
    r_tail_d  = r_tail_q;
    r_err_d   = r_err_q;
    r_last_d  = r_last_q;
    push_o    = 1'b0;
    mem_o.we    = 1'b0;
    mem_o.waddr = slot;
    mem_o.wdata = flag_q;
    mem_o.raddr = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          flag_d    = in_i.frame_is_speech;
          tail_d    = in_i.tail_samples;
          r_valid_d = 1'b0;
          r_idx_d   = '0;
          r_tail_d  = '0;
          r_err_d   = 1'b0;
          r_last_d  = 1'b0;
          ret_d     = ST_IDLE;
          if (in_i.op == sed_pkg::OP_FRAME) begin
            // fetch head flag, needed if the push evicts it
            state_d = ST_EVICT;
          end else if (tail_bad) begin
            r_err_d  = 1'b1;
            r_last_d = 1'b1;
            state_d  = ST_EMIT;
          end else if (!speech_q) begin
            r_last_d = 1'b1;
            state_d  = ST_EMIT;
          end else begin
            speech_d = 1'b0;
            end_d    = qsf_q;
            extra_d  = '0;
            all_sp_d = 1'b1;
            state_d  = ST_DCHK;
          end
        end
      end

      ST_EVICT: begin
        mem_o.we    = 1'b1;
        mem_o.raddr = head_push;
        fwd_d       = (head_push == slot);
        head_d      = head_push;
        occ_d       = full ? occ_q : occ_q + sed_pkg::CntW'(1);
        cnt_d       = cnt_push;
        qsf_d       = qsf_push;
        seen_d      = seen_q + sed_pkg::FrameW'(1);
        ending_d    = 1'b0;
        if (speech_q) begin
          ending_d = (sed_pkg::CmpW'(cnt_push) < sed_pkg::CmpW'(cfg_i.end_thr));
          state_d  = ST_POP;
        end else if (sed_pkg::CmpW'(cnt_push) > sed_pkg::CmpW'(cfg_i.start_thr)) begin
          start_d  = qsf_push;
          end_d    = '0;
          extra_d  = '0;
          speech_d = 1'b1;
          state_d  = ST_POP;
        end else begin
          state_d  = ST_EMIT;
        end
      end

      ST_POP: begin
        r_valid_d = 1'b1;
        r_idx_d   = qsf_q;
        qsf_d     = qsf_q + sed_pkg::FrameW'(1);
        head_d    = head_inc;
        occ_d     = occ_q - sed_pkg::CntW'(1);
        cnt_d     = cnt_q - sed_pkg::CntW'(pop_flag);
        if (ending_q) begin
          end_d    = qsf_q + sed_pkg::FrameW'(1);
          extra_d  = '0;
          speech_d = 1'b0;
        end
        state_d = ST_EMIT;
      end

      ST_DCHK: begin
        state_d = (occ_q == '0) ? ST_DFIN : ST_DPOP;
      end

      ST_DPOP: begin
        qsf_d  = qsf_q + sed_pkg::FrameW'(1);
        head_d = head_inc;
        occ_d  = occ_q - sed_pkg::CntW'(1);
        cnt_d  = cnt_q - sed_pkg::CntW'(mem_rdata_i);
        if (mem_rdata_i) begin
          end_d     = qsf_q + sed_pkg::FrameW'(1);
          r_valid_d = 1'b1;
          r_idx_d   = qsf_q;
          ret_d     = ST_DCHK;
          state_d   = ST_EMIT;
        end else begin
          // stop at the first non-speech flag
          all_sp_d = 1'b0;
          state_d  = ST_DFIN;
        end
      end

      ST_DFIN: begin
        r_valid_d = 1'b0;
        r_idx_d   = '0;
        r_last_d  = 1'b1;
        r_tail_d  = '0;
        if (all_sp_q) begin
          r_tail_d = tail_q;
          end_d    = seen_q;
          extra_d  = tail_q;
        end
        head_d  = '0;
        occ_d   = '0;
        cnt_d   = '0;
        ret_d   = ST_IDLE;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = ret_q;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // A window rewrite empties the queue
    if (cfg_i.clear_queue) begin
      head_d = '0;
      occ_d  = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      head_q   <= '0;
      occ_q    <= '0;
      cnt_q    <= '0;
      speech_q <= 1'b0;
      qsf_q    <= '0;
      seen_q   <= '0;
      start_q  <= '0;
      end_q    <= '0;
      extra_q  <= '0;
      ending_q <= 1'b0;
      fwd_q    <= 1'b0;
      all_sp_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      head_q   <= head_d;
      occ_q    <= occ_d;
      cnt_q    <= cnt_d;
      speech_q <= speech_d;
      qsf_q    <= qsf_d;
      seen_q   <= seen_d;
      start_q  <= start_d;
      end_q    <= end_d;
      extra_q  <= extra_d;
      ending_q <= ending_d;
      fwd_q    <= fwd_d;
      all_sp_q <= all_sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q    <= flag_d;
    tail_q    <= tail_d;
    r_valid_q <= r_valid_d;
    r_idx_q   <= r_idx_d;
    r_tail_q  <= r_tail_d;
    r_err_q   <= r_err_d;
    r_last_q  <= r_last_d;
  end

  always_comb begin
    res_o.frame_valid       = r_valid_q;
    res_o.frame_index       = r_idx_q;
    res_o.tail_out          = r_tail_q;
    res_o.speech_active     = speech_q;
    res_o.segment_start     = start_q;
    res_o.segment_end       = end_q;
    res_o.segment_end_extra = extra_q;
    res_o.error             = r_err_q;
    res_o.last              = r_last_q;
  end

endmodule

/* rtl/core/speech_endpoint_detector_core.sv */
// Top level of the speech endpoint detector: config, flag ring, sequencer, result register.
//
//  channel    dir  modport  payload
//  ---------  ---  -------  -------------------------------------------------------
//  frame_i    in   sink     op, frame_is_speech, tail_samples
//  result_o   out  source   frame_valid, frame_index, tail_out, speech_active,
//                           segment_start, segment_end, segment_end_extra, error, last
//  cfg_i      in   sink     index (register number), data
//
// A frame item runs evict, then pop if the oldest frame is released, then emit; the flag
// ring read is registered. End of stream goes to emit, or drains by check, pop and emit
// per speech frame, then finish and emit. rst_ni clears control state; ring has no reset.
// frame_i is taken only between items; a stalled result_o holds its transfer in the
// output register and the sequencer waits in its emit step until the register frees.
module speech_endpoint_detector_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  sed_frame_if.sink     frame_i,
  sed_result_if.source  result_o,
  sed_cfg_if.sink       cfg_i
);

  sed_pkg::cfg_t     cfg;
  sed_pkg::in_t      in_item;
  sed_pkg::res_t     res;
  sed_pkg::res_t     out_q;
  sed_pkg::mem_req_t mem_req;
  logic              mem_rdata;
  logic              push;
  logic              out_valid_q;
  logic              out_free;

  // Register file; a window write also empties the queue
  sed_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Voice-activity flags of the decision window
  sed_flag_mem u_flag_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    in_item.op              = frame_i.op;
    in_item.frame_is_speech = frame_i.frame_is_speech;
    in_item.tail_samples    = frame_i.tail_samples;
  end

  // Push, evict, decide and release; drain on end of stream
  sed_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (frame_i.valid),
    .in_ready_o  (frame_i.ready),
    .in_i        (in_item),
    .out_free_i  (out_free),
    .push_o      (push),
    .res_o       (res),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Output register: load on push, drop when the sink takes the transfer
  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  always_comb begin
    result_o.valid             = out_valid_q;
    result_o.frame_valid       = out_q.frame_valid;
    result_o.frame_index       = out_q.frame_index;
    result_o.tail_out          = out_q.tail_out;
    result_o.speech_active     = out_q.speech_active;
    result_o.segment_start     = out_q.segment_start;
    result_o.segment_end       = out_q.segment_end;
    result_o.segment_end_extra = out_q.segment_end_extra;
    result_o.error             = out_q.error;
    result_o.last              = out_q.last;
  end

endmodule

/* tb/speech_endpoint_detector_core_tb.sv */
// Self-checking testbench for the speech endpoint detector core, with an in-bench predictor.
`timescale 1ns / 100ps

module speech_endpoint_detector_core_tb;
  import sed_pkg::*;

  localparam int unsigned StallLimit   = 2000; // cycles with no transfer on any channel
  localparam int unsigned SettleCycles = 12;   // idle time before register writes
  localparam int unsigned TailCycles   = 20;   // quiet time after the last result

  // ---------------------------------------------------------------------------
  // Endpoint scoreboard: mirrors the detector state, queues the results that
  // each accepted item must produce, and checks results as they arrive.
  // ---------------------------------------------------------------------------
  class endpoint_scoreboard;
    logic [WinW-1:0]   window_frames;
    logic [ThrW-1:0]   start_thr;
    logic [ThrW-1:0]   end_thr;
    logic [SampW-1:0]  frame_samples;

    bit                flag_ring [MaxWindow];
    logic [PtrW-1:0]   head;
    logic [CntW-1:0]   occupancy;
    logic [CntW-1:0]   speech_flags;
    bit                speaking;
    logic [FrameW-1:0] queue_start;
    logic [FrameW-1:0] frames_seen;
    logic [FrameW-1:0] start_mark;
    logic [FrameW-1:0] end_mark;
    logic [SampW-1:0]  end_extra;

    res_t              expected_results [$];
    int                mismatches;

    function new();
      window_frames = WindowRst;
      start_thr     = StartThrRst;
      end_thr       = EndThrRst;
      frame_samples = FrameSamplesRst;
      foreach (flag_ring[i]) flag_ring[i] = 1'b0;
      clear_queue();
      speaking    = 1'b0;
      queue_start = '0;
      frames_seen = '0;
      start_mark  = '0;
      end_mark    = '0;
      end_extra   = '0;
      mismatches  = 0;
    endfunction

    function void clear_queue();
      head         = '0;
      occupancy    = '0;
      speech_flags = '0;
    endfunction

    function int unsigned eff_window();
      int unsigned w = 32'(window_frames);
      if (w < 2) w = 2;
      if (w > MaxWindow) w = MaxWindow;
      return w;
    endfunction

    function int unsigned eff_frame_samples();
      int unsigned f = 32'(frame_samples);
      if (f > MaxFrameSamples) f = MaxFrameSamples;
      return f;
    endfunction

    function void apply_register(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_WINDOW: begin
          window_frames = data[WinW-1:0];
          clear_queue();
        end
        CFG_START_THR:     start_thr     = data[ThrW-1:0];
        CFG_END_THR:       end_thr       = data[ThrW-1:0];
        CFG_FRAME_SAMPLES: frame_samples = data[SampW-1:0];
        default: ;
      endcase
    endfunction

    // Queue one result carrying the segment state as it stands now.
    function void push_expected(bit valid, logic [FrameW-1:0] idx, logic [SampW-1:0] tail,
                                bit err, bit last);
      res_t r;
      r.frame_valid       = valid;
      r.frame_index       = idx;
      r.tail_out          = tail;
      r.speech_active     = speaking;
      r.segment_start     = start_mark;
      r.segment_end       = end_mark;
      r.segment_end_extra = end_extra;
      r.error             = err;
      r.last              = last;
      expected_results.push_back(r);
    endfunction

    // Drop the oldest flag and hand back its frame number.
    function bit pop_oldest(int unsigned w, output logic [FrameW-1:0] idx);
      bit f;
      f            = flag_ring[head % w];
      idx          = queue_start;
      queue_start  = queue_start + 1;
      head         = PtrW'((head + 1) % w);
      occupancy    = occupancy - CntW'(1);
      speech_flags = speech_flags - f;
      return f;
    endfunction

    function void note_item(in_t item);
      int unsigned       w;
      int unsigned       slot;
      logic [FrameW-1:0] idx;
      logic [SampW-1:0]  tail_out;
      w        = eff_window();
      idx      = '0;
      tail_out = '0;

      if (item.op == OP_FRAME) begin
        if (occupancy > w) occupancy = CntW'(w);
        slot = (head + occupancy) % w;
        if (occupancy == w) begin
          // full window: the oldest flag falls out unreleased
          speech_flags = speech_flags - flag_ring[slot];
          queue_start  = queue_start + 1;
          head         = PtrW'((head + 1) % w);
        end else begin
          occupancy = occupancy + CntW'(1);
        end
        flag_ring[slot] = item.frame_is_speech;
        speech_flags    = speech_flags + item.frame_is_speech;
        frames_seen     = frames_seen + 1;

        if (speaking) begin
          if (speech_flags < end_thr) begin
            void'(pop_oldest(w, idx));
            end_mark  = queue_start;
            end_extra = '0;
            speaking  = 1'b0;
            push_expected(1'b1, idx, '0, 1'b0, 1'b0);
            return;
          end
        end else if (speech_flags > start_thr) begin
          start_mark = queue_start;
          end_mark   = '0;
          end_extra  = '0;
          speaking   = 1'b1;
        end
        if (speaking && occupancy > 0) begin
          void'(pop_oldest(w, idx));
          push_expected(1'b1, idx, '0, 1'b0, 1'b0);
        end else begin
          push_expected(1'b0, '0, '0, 1'b0, 1'b0);
        end
        return;
      end

      // end of stream
      if (item.tail_samples > eff_frame_samples()) begin
        push_expected(1'b0, '0, '0, 1'b1, 1'b1);
        return;
      end
      if (!speaking) begin
        push_expected(1'b0, '0, '0, 1'b0, 1'b1);
        return;
      end
      speaking  = 1'b0;
      end_mark  = queue_start;
      end_extra = '0;
      if (occupancy > w) occupancy = CntW'(w);
      while (occupancy > 0) begin
        if (pop_oldest(w, idx)) begin
          end_mark = queue_start;
          push_expected(1'b1, idx, '0, 1'b0, 1'b0);
        end else begin
          break;
        end
      end
      // whole queue was speech: the segment runs to the end with the tail
      if (occupancy == 0 && end_mark == queue_start) begin
        tail_out  = item.tail_samples;
        end_mark  = frames_seen;
        end_extra = item.tail_samples;
      end
      clear_queue();
      push_expected(1'b0, '0, tail_out, 1'b0, 1'b1);
    endfunction

    function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: frame_index %0d, last %0b",
               got.frame_index, got.last);
        mismatches++;
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("frame_valid", 64'(exp_r.frame_valid), 64'(got.frame_valid));
      compare_field("frame_index", 64'(exp_r.frame_index), 64'(got.frame_index));
      compare_field("tail_out", 64'(exp_r.tail_out), 64'(got.tail_out));
      compare_field("speech_active", 64'(exp_r.speech_active), 64'(got.speech_active));
      compare_field("segment_start", 64'(exp_r.segment_start), 64'(got.segment_start));
      compare_field("segment_end", 64'(exp_r.segment_end), 64'(got.segment_end));
      compare_field("segment_end_extra", 64'(exp_r.segment_end_extra),
                    64'(got.segment_end_extra));
      compare_field("error", 64'(exp_r.error), 64'(got.error));
      compare_field("last", 64'(exp_r.last), 64'(got.last));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels and the device under test
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  bit   calm;            // set to suppress idling on both sides
  int unsigned stall_cycles;

  endpoint_scoreboard sb = new();

  sed_frame_if  frame_if ();
  sed_result_if result_if ();
  sed_cfg_if    cfg_if ();

  speech_endpoint_detector_core dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .frame_i  (frame_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Drive every input to a known value before the first edge.
  initial begin
    rst_n                 = 1'b0;
    calm                  = 1'b0;
    frame_if.valid        = 1'b0;
    frame_if.op           = OP_FRAME;
    frame_if.frame_is_speech = 1'b0;
    frame_if.tail_samples = '0;
    result_if.ready       = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_WINDOW;
    cfg_if.data           = '0;
  end

  // Result sink: check each transfer, then pick the ready level for the next cycle.
  // Values read here are the ones sampled at this edge.
  always @(posedge clk) begin
    res_t got;
    if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      got.frame_valid       = result_if.frame_valid;
      got.frame_index       = result_if.frame_index;
      got.tail_out          = result_if.tail_out;
      got.speech_active     = result_if.speech_active;
      got.segment_start     = result_if.segment_start;
      got.segment_end       = result_if.segment_end;
      got.segment_end_extra = result_if.segment_end_extra;
      got.error             = result_if.error;
      got.last              = result_if.last;
      sb.check_result(got);
    end
    if (!rst_n) result_if.ready <= 1'b0;
    else        result_if.ready <= calm || ($urandom_range(99) >= 31);
  end

  // Count cycles with no transfer on any channel; the watchdog below acts on it.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Hold valid low for a random number of cycles; each idle cycle advances time.
  task automatic idle_gap();
    while (!calm && $urandom_range(99) < 31) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Present one item and hold it until the transfer, then note it.
  task automatic send_item(op_e op, logic speech, logic [SampW-1:0] tail);
    in_t item;
    idle_gap();
    frame_if.valid           <= 1'b1;
    frame_if.op              <= op;
    frame_if.frame_is_speech <= speech;
    frame_if.tail_samples    <= tail;
    @(posedge clk);
    while (frame_if.ready !== 1'b1) @(posedge clk);
    item.op              = op;
    item.frame_is_speech = speech;
    item.tail_samples    = tail;
    sb.note_item(item);
  endtask

  // Drop valid and hold off until every pending result has arrived.
  // Always wait on a clock edge first so valid is never lowered and raised in one step.
  task automatic wait_drained();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CfgDataW'(value);
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    sb.apply_register(idx, CfgDataW'(value));
  endtask

  // Rewrite all registers once the block has gone quiet.
  task automatic configure(int unsigned win, int unsigned start_thr, int unsigned end_thr,
                           int unsigned fs);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_START_THR, start_thr);
    write_reg(CFG_END_THR, end_thr);
    write_reg(CFG_FRAME_SAMPLES, fs);
    cfg_if.valid <= 1'b0;
  endtask

  // Random traffic: runs of speech or silence with a little flip noise, broken up by
  // end-of-stream items whose tails are mostly legal, sometimes too long.
  task automatic run_phase(int n_items, int speech_pct);
    int               sent;
    int unsigned      run_len;
    int unsigned      fs;
    int unsigned      pick;
    bit               level;
    logic [SampW-1:0] tail;
    sent = 0;
    while (sent < n_items) begin
      level   = ($urandom_range(99) < speech_pct);
      run_len = $urandom_range(2 * sb.eff_window() + 2, 1);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        send_item(OP_FRAME, ($urandom_range(99) < 3) ? !level : level, SampW'($urandom));
        sent++;
      end
      if (sent < n_items && $urandom_range(99) < 30) begin
        fs   = sb.eff_frame_samples();
        pick = $urandom_range(99);
        if (pick < 80)      tail = SampW'($urandom_range(fs, 0));
        else if (pick < 95) tail = SampW'($urandom_range(2047, fs + 1));
        else                tail = SampW'($urandom);
        send_item(OP_EOS, 1'($urandom_range(1)), tail);
        sent++;
        if ($urandom_range(99) < 15) wait_drained();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings (window 10, start above 9, end below 1, 480 samples).
    // End of stream outside speech, then tails just over the limit and at the field maximum.
    send_item(OP_EOS, 1'b0, SampW'(0));
    send_item(OP_EOS, 1'b1, SampW'(481));
    send_item(OP_EOS, 1'b0, SampW'(2047));
    // Fill the window with speech: the tenth frame opens a segment and releases frame 0.
    for (int i = 0; i < 10; i++) send_item(OP_FRAME, 1'b1, SampW'(2047));
    send_item(OP_FRAME, 1'b0, SampW'(0));
    // Tail too long while in speech: error, nothing changes.
    send_item(OP_EOS, 1'b0, SampW'(1024));
    // Drain stops at the silent frame, so no tail is appended.
    send_item(OP_EOS, 1'b1, SampW'(480));
    // Whole queue speech at end of stream: segment closes at frames seen plus the tail.
    for (int i = 0; i < 10; i++) send_item(OP_FRAME, 1'b1, SampW'(0));
    send_item(OP_EOS, 1'b0, SampW'(5));

    // Tiny window, start on any speech flag, never end on frames, one-sample frames.
    configure(2, 0, 0, 1);
    run_phase(25, 50);

    // Largest window and highest thresholds: start only on a full window of speech.
    configure(32, 31, 31, 1024);
    run_phase(45, 90);

    // Window below range clamps to 2; zero frame size makes every nonzero tail an error.
    configure(0, 1, 1, 0);
    run_phase(20, 50);

    // Window and frame size above range clamp; run this stretch with no idling.
    configure(63, 20, 5, 2047);
    calm = 1'b1;
    run_phase(35, 75);
    calm = 1'b0;

    // End threshold above start threshold.
    configure(1, 1, 2, 100);
    run_phase(20, 60);

    configure(8, 5, 3, 480);
    run_phase(20, 60);

    // Any values the register fields allow.
    configure($urandom_range(63), $urandom_range(31), $urandom_range(31), $urandom_range(2047));
    run_phase(15, 65);

    configure(10, 9, 1, 480);
    run_phase(15, 70);

    // Wait for the last result, then give the block time to show anything extra.
    wait_drained();
    repeat (TailCycles) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sed_pkg.sv
rtl/core/sed_intf.sv
rtl/core/sed_cfg.sv
rtl/core/sed_flag_mem.sv
rtl/core/sed_seq.sv
rtl/core/speech_endpoint_detector_core.sv
tb/speech_endpoint_detector_core_tb.sv
